FILE: design/flow_key_header_parser_unit_defines.svh
// Assertion macros used by the flow key header parser top file.
`ifndef FLOW_KEY_HEADER_PARSER_UNIT_DEFINES_SVH
`define FLOW_KEY_HEADER_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define FKP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that cons holds in the cycle after ante.
`define FKP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FKP_ASSERT_NOW(label, ante, cons, msg)
`define FKP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: design/fkp_pkg.sv
// Types and protocol constants of the flow key header parser.
package fkp_pkg;

    // Link layer and transport protocol numbers
    localparam logic [15:0] ETYPE_IPV4          = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6          = 16'h86DD;
    localparam logic [7:0]  PROTO_ICMP          = 8'd1;
    localparam logic [7:0]  PROTO_TCP           = 8'd6;
    localparam logic [7:0]  PROTO_UDP           = 8'd17;
    localparam logic [7:0]  PROTO_ICMPV6        = 8'd58;
    localparam logic [15:0] FRAG_MORE           = 16'h2000;
    localparam logic [15:0] FRAG_OFS_MASK       = 16'h1FFF;
    localparam logic [7:0]  ICMP4_ECHO_RSP      = 8'd0;
    localparam logic [7:0]  ICMP4_ECHO_REQ      = 8'd8;
    localparam logic [7:0]  ICMP4_TSTAMP_REQ    = 8'd13;
    localparam logic [7:0]  ICMP4_TSTAMP_RSP    = 8'd14;
    localparam logic [7:0]  ICMP6_ECHO_REQ      = 8'd128;
    localparam logic [7:0]  ICMP6_ECHO_RSP      = 8'd129;

    // Header geometry
    localparam logic [3:0]  IPV4_VERSION        = 4'd4;
    localparam logic [3:0]  IPV6_VERSION        = 4'd6;
    localparam logic [3:0]  IPV4_MIN_IHL        = 4'd5;
    localparam logic [7:0]  IPV4_MIN_LEN        = 8'd20;
    localparam logic [7:0]  IPV6_HDR_LEN        = 8'd40;
    localparam logic [6:0]  TCP_MIN_LEN         = 7'd20;
    localparam logic [6:0]  SHORT_L4_LEN        = 7'd8;
    localparam logic [7:0]  OFFSET_MAX          = 8'd255;

    typedef enum logic {
        PH_IDLE,
        PH_PACKET
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_UNHANDLED,
        ST_ERROR
    } t_status;

    typedef enum logic [1:0] {
        FAM_NONE,
        FAM_IPV4,
        FAM_IPV6
    } t_family;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] ether_type;
        logic        first_byte;
        logic        last_byte;
    } t_item;

    typedef struct packed {
        t_status     status;
        t_family     family;
        logic [7:0]  protocol;
        logic        fragment;
        logic [63:0] source_high;
        logic [63:0] source_low;
        logic [63:0] dest_high;
        logic [63:0] dest_low;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] icmp_type_code;
        logic [15:0] icmp_ident;
    } t_result;

endpackage

FILE: design/fkp_in_if.sv
// Byte channel into the parser: one packet byte per word.
interface fkp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [15:0] ether_type;
    logic        first_byte;
    logic        last_byte;

    modport source (output valid, output data_byte, output ether_type,
                    output first_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input ether_type,
                    input first_byte, input last_byte, output ready);
endinterface

FILE: design/fkp_out_if.sv
// Result channel out of the parser: one flow key per word.
interface fkp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [1:0]  family;
    logic [7:0]  protocol;
    logic        fragment;
    logic [63:0] source_high;
    logic [63:0] source_low;
    logic [63:0] dest_high;
    logic [63:0] dest_low;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] icmp_type_code;
    logic [15:0] icmp_ident;

    modport source (output valid, output status, output family, output protocol,
                    output fragment, output source_high, output source_low,
                    output dest_high, output dest_low, output source_port,
                    output dest_port, output icmp_type_code, output icmp_ident,
                    input ready);
    modport sink   (input valid, input status, input family, input protocol,
                    input fragment, input source_high, input source_low,
                    input dest_high, input dest_low, input source_port,
                    input dest_port, input icmp_type_code, input icmp_ident,
                    output ready);
endinterface

FILE: design/fkp_capture.sv
// Per-packet capture state and the flow key built from it on the last byte.
module fkp_capture (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  fkp_pkg::t_item  i_item,
    output logic            o_push,
    output fkp_pkg::t_result o_result
);
    import fkp_pkg::*;

    t_phase      r_phase,    n_phase;
    logic [7:0]  r_offset,   n_offset;
    logic [15:0] r_etype,    n_etype;
    logic [3:0]  r_hdr_words, n_hdr_words;
    logic        r_err,      n_err;
    logic [15:0] r_flags,    n_flags;
    logic [63:0] r_src_hi,   n_src_hi;
    logic [63:0] r_src_lo,   n_src_lo;
    logic [63:0] r_dst_hi,   n_dst_hi;
    logic [63:0] r_dst_lo,   n_dst_lo;
    logic [7:0]  r_proto,    n_proto;
    logic [31:0] r_ports,    n_ports;
    logic [31:0] r_icmp,     n_icmp;

    logic [7:0]  w_pos;
    logic [5:0]  w_l4_start;
    logic [6:0]  w_l4_end;
    logic [7:0]  w_rel;
    logic        w_l4_hit;

    // Advance the capture state on every accepted word
    always_comb begin
        n_phase     = r_phase;
        n_offset    = r_offset;
        n_etype     = r_etype;
        n_hdr_words = r_hdr_words;
        n_err       = r_err;
        n_flags     = r_flags;
        n_src_hi    = r_src_hi;
        n_src_lo    = r_src_lo;
        n_dst_hi    = r_dst_hi;
        n_dst_lo    = r_dst_lo;
        n_proto     = r_proto;
        n_ports     = r_ports;
        n_icmp      = r_icmp;
        w_pos       = '0;
        w_l4_start  = '0;
        w_l4_end    = '0;
        w_rel       = '0;
        w_l4_hit    = 1'b0;
        if (i_accept) begin
            // Open a fresh packet on a first byte or on any byte while idle
            if (i_item.first_byte || (r_phase == PH_IDLE)) begin
                n_phase     = PH_PACKET;
                n_offset    = '0;
                n_etype     = i_item.ether_type;
                n_hdr_words = '0;
                n_err       = 1'b0;
                n_flags     = '0;
                n_src_hi    = '0;
                n_src_lo    = '0;
                n_dst_hi    = '0;
                n_dst_lo    = '0;
                n_proto     = '0;
                n_ports     = '0;
                n_icmp      = '0;
            end
            w_pos = n_offset;
            if (n_etype == ETYPE_IPV4) begin
                // Transport header begins at four bytes per header word
                w_l4_start = {n_hdr_words, 2'b00};
                w_l4_end   = {1'b0, w_l4_start} + SHORT_L4_LEN;
                if (w_pos == 8'd0) begin
                    n_hdr_words = i_item.data_byte[3:0];
                    n_err = (i_item.data_byte[7:4] != IPV4_VERSION) ||
                            (i_item.data_byte[3:0] < IPV4_MIN_IHL);
                end else if ((w_pos == 8'd6) || (w_pos == 8'd7)) begin
                    n_flags = {n_flags[7:0], i_item.data_byte};
                end else if (w_pos == 8'd9) begin
                    n_proto = i_item.data_byte;
                end else if ((w_pos >= 8'd12) && (w_pos < 8'd16)) begin
                    n_src_lo = {n_src_lo[55:0], i_item.data_byte};
                end else if ((w_pos >= 8'd16) && (w_pos < 8'd20)) begin
                    n_dst_lo = {n_dst_lo[55:0], i_item.data_byte};
                end
                w_l4_hit = (w_pos >= IPV4_MIN_LEN) && (w_pos >= {2'b00, w_l4_start}) &&
                           (w_pos < {1'b0, w_l4_end});
                w_rel    = w_pos - {2'b00, w_l4_start};
            end else if (n_etype == ETYPE_IPV6) begin
                if (w_pos == 8'd0) begin
                    n_err = (i_item.data_byte[7:4] != IPV6_VERSION);
                end else if (w_pos == 8'd6) begin
                    n_proto = i_item.data_byte;
                end else if ((w_pos >= 8'd8) && (w_pos < 8'd16)) begin
                    n_src_hi = {n_src_hi[55:0], i_item.data_byte};
                end else if ((w_pos >= 8'd16) && (w_pos < 8'd24)) begin
                    n_src_lo = {n_src_lo[55:0], i_item.data_byte};
                end else if ((w_pos >= 8'd24) && (w_pos < 8'd32)) begin
                    n_dst_hi = {n_dst_hi[55:0], i_item.data_byte};
                end else if ((w_pos >= 8'd32) && (w_pos < IPV6_HDR_LEN)) begin
                    n_dst_lo = {n_dst_lo[55:0], i_item.data_byte};
                end
                w_l4_hit = (w_pos >= IPV6_HDR_LEN) && (w_pos < IPV6_HDR_LEN + 8'd8);
                w_rel    = w_pos - IPV6_HDR_LEN;
            end
            // Capture the leading transport bytes
            if (w_l4_hit) begin
                if (w_rel[2:0] < 3'd4) begin
                    n_ports = {n_ports[23:0], i_item.data_byte};
                end
                case (w_rel[2:0])
                    3'd0:    n_icmp[31:24] = i_item.data_byte;
                    3'd1:    n_icmp[23:16] = i_item.data_byte;
                    3'd4:    n_icmp[15:8]  = i_item.data_byte;
                    3'd5:    n_icmp[7:0]   = i_item.data_byte;
                    default: ;
                endcase
            end
            if (n_offset != OFFSET_MAX) begin
                n_offset = n_offset + 8'd1;
            end
            if (i_item.last_byte) begin
                n_phase = PH_IDLE;
            end
        end
    end

    logic        w_is_ip;
    logic [5:0]  w_fin_start;
    logic [6:0]  w_need;
    logic        w_known;
    logic        w_id_kind;
    logic [7:0]  w_type;

    // Build the flow key from the state as it stands after this word
    always_comb begin
        o_result    = '0;
        o_result.status = ST_OK;
        o_result.family = FAM_NONE;
        w_is_ip     = 1'b0;
        w_fin_start = '0;
        w_need      = SHORT_L4_LEN;
        w_known     = 1'b0;
        w_id_kind   = 1'b0;
        w_type      = n_icmp[31:24];
        if (n_etype == ETYPE_IPV4) begin
            if ((n_offset < IPV4_MIN_LEN) || n_err) begin
                o_result.status = ST_ERROR;
            end else begin
                o_result.family = FAM_IPV4;
                w_fin_start = {n_hdr_words, 2'b00};
                w_is_ip = 1'b1;
            end
        end else if (n_etype == ETYPE_IPV6) begin
            if ((n_offset < IPV6_HDR_LEN) || n_err) begin
                o_result.status = ST_ERROR;
            end else begin
                o_result.family      = FAM_IPV6;
                o_result.source_high = n_src_hi;
                o_result.dest_high   = n_dst_hi;
                w_fin_start = IPV6_HDR_LEN[5:0];
                w_is_ip = 1'b1;
            end
        end else begin
            o_result.status = ST_UNHANDLED;
        end
        if (w_is_ip) begin
            o_result.protocol   = n_proto;
            o_result.source_low = n_src_lo;
            o_result.dest_low   = n_dst_lo;
            if ((o_result.family == FAM_IPV4) &&
                ((n_flags & (FRAG_MORE | FRAG_OFS_MASK)) != 16'd0)) begin
                // Fragments stop here
                o_result.fragment = 1'b1;
            end else begin
                if (n_proto == PROTO_TCP) begin
                    w_need  = TCP_MIN_LEN;
                    w_known = 1'b1;
                end else if (n_proto inside {PROTO_UDP, PROTO_ICMP, PROTO_ICMPV6}) begin
                    w_need  = SHORT_L4_LEN;
                    w_known = 1'b1;
                end
                if (!w_known) begin
                    o_result.status = ST_UNHANDLED;
                end else if (n_offset < ({1'b0, {1'b0, w_fin_start} + w_need})) begin
                    o_result.status = ST_ERROR;
                end else if ((n_proto == PROTO_TCP) || (n_proto == PROTO_UDP)) begin
                    o_result.source_port = n_ports[31:16];
                    o_result.dest_port   = n_ports[15:0];
                end else begin
                    o_result.icmp_type_code = n_icmp[31:16];
                    if (n_proto == PROTO_ICMP) begin
                        w_id_kind = w_type inside {ICMP4_ECHO_REQ, ICMP4_ECHO_RSP,
                                                   ICMP4_TSTAMP_REQ, ICMP4_TSTAMP_RSP};
                    end else begin
                        w_id_kind = w_type inside {ICMP6_ECHO_REQ, ICMP6_ECHO_RSP};
                    end
                    // A zero identifier reads as one
                    if (w_id_kind) begin
                        o_result.icmp_ident = (n_icmp[15:0] == 16'd0) ? 16'd1 : n_icmp[15:0];
                    end
                end
            end
        end
    end

    assign o_push = i_accept && i_item.last_byte;

    // Hold the phase under reset; capture fields are cleared on packet start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_offset    <= n_offset;
        r_etype     <= n_etype;
        r_hdr_words <= n_hdr_words;
        r_err       <= n_err;
        r_flags     <= n_flags;
        r_src_hi    <= n_src_hi;
        r_src_lo    <= n_src_lo;
        r_dst_hi    <= n_dst_hi;
        r_dst_lo    <= n_dst_lo;
        r_proto     <= n_proto;
        r_ports     <= n_ports;
        r_icmp      <= n_icmp;
    end

endmodule

FILE: design/fkp_out_skid.sv
// Result register with a skid stage in front of the output channel.
module fkp_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fkp_pkg::t_result i_result,
    output logic             o_ready,
    fkp_out_if.source        o_out
);
    import fkp_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out_data,  r_skid_data;
    logic    w_out_free;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign o_ready    = !r_skid_valid;

    // Refill the output from the skid first, else from a new word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_result;
        end else if (i_push) begin
            r_skid_data <= i_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_data.status;
    assign o_out.family         = r_out_data.family;
    assign o_out.protocol       = r_out_data.protocol;
    assign o_out.fragment       = r_out_data.fragment;
    assign o_out.source_high    = r_out_data.source_high;
    assign o_out.source_low     = r_out_data.source_low;
    assign o_out.dest_high      = r_out_data.dest_high;
    assign o_out.dest_low       = r_out_data.dest_low;
    assign o_out.source_port    = r_out_data.source_port;
    assign o_out.dest_port      = r_out_data.dest_port;
    assign o_out.icmp_type_code = r_out_data.icmp_type_code;
    assign o_out.icmp_ident     = r_out_data.icmp_ident;

endmodule

FILE: design/flow_key_header_parser_unit.sv
// Flow key header parser: takes a packet one byte per word from the network
// header onward, with the ether type sampled on the first byte, and gives one
// flow key word (status, family, protocol, fragment flag, addresses, ports or
// ICMP type, code and identifier) for each byte marked last. A byte is taken
// every cycle while input ready is high. The output holds one finished word
// and a skid stage holds one more, so bytes keep flowing while a result
// waits; input ready drops only when both are full. A byte that arrives with
// no packet open starts a new one, and a first byte inside an open packet
// drops that packet silently.
module flow_key_header_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fkp_in_if.sink     i_in,
    fkp_out_if.source  o_out
);
    import fkp_pkg::*;

`include "flow_key_header_parser_unit_defines.svh"

    logic    w_accept;
    logic    w_ready;
    logic    w_push;
    t_item   w_item;
    t_result w_result;

    assign i_in.ready = w_ready;
    assign w_accept   = i_in.valid && w_ready;

    // Gather the byte word into one struct
    assign w_item.data_byte  = i_in.data_byte;
    assign w_item.ether_type = i_in.ether_type;
    assign w_item.first_byte = i_in.first_byte;
    assign w_item.last_byte  = i_in.last_byte;

    fkp_capture u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (w_item),
        .o_push   (w_push),
        .o_result (w_result)
    );

    fkp_out_skid u_out_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_result),
        .o_ready  (w_ready),
        .o_out    (o_out)
    );

    // A full skid stage means the output is holding a word
    `FKP_ASSERT_NOW(a_skid_behind_output, !w_ready, o_out.valid, "skid full with output empty")
    // A taken last byte leaves a valid word on the output in the next cycle
    `FKP_ASSERT_NEXT(a_last_gives_result, w_accept && i_in.last_byte, o_out.valid, "result lost")
    // Fragments are only flagged on good IPv4 headers
    `FKP_ASSERT_NOW(a_fragment_ipv4, o_out.valid && o_out.fragment, (o_out.family == FAM_IPV4) && (o_out.status == ST_OK), "fragment outside IPv4")
    // No family means no addresses captured
    `FKP_ASSERT_NOW(a_none_no_addr, o_out.valid && (o_out.family == FAM_NONE), (o_out.source_low == 64'd0) && (o_out.dest_low == 64'd0), "address without family")

endmodule
